### hdl/bta_pkg.sv
// Shared constants, types and helpers of the buddy tree allocator.
package bta_pkg;

	localparam int UNIT_SHIFT = 9;
	localparam int TREE_DEPTH = 16;
	localparam int LAYER_W    = 5;
	localparam int UNIT_W     = 16;
	localparam int ADDR_W     = 25;
	localparam int BYTES_W    = 26;
	localparam int CLIENT_W   = 2;
	localparam int WORD_W     = 32;
	localparam int BIT_W      = 5;
	localparam int WIDX_W     = 11;
	localparam int NODE_WORDS = 4100;
	localparam int NODE_AW    = 13;
	localparam int UNITS_W    = 18;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 32;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_LRD,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_SUB_RD,
		ST_SUB_WR,
		ST_ANC_RD,
		ST_ANC_WR,
		ST_FINISH,
		ST_RESULT
	} state_t;

	typedef struct packed {
		op_t                 op;
		logic                oversize;
		logic [LAYER_W-1:0]  layer;
		logic [CLIENT_W-1:0] client;
		logic [UNIT_W-1:0]   unit;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              failed;
	} res_t;

	typedef struct packed {
		logic ready;
		logic res_valid;
	} eng_stat_t;

	// first word of a layer; layers 0..4 share nothing, one word each
	function automatic logic [NODE_AW-1:0] layer_base(input logic [LAYER_W-1:0] d);
		logic [NODE_AW-1:0] r;
		if (d < LAYER_W'(5)) begin
			r = NODE_AW'(d);
		end else begin
			r = (NODE_AW'(1) << (d - LAYER_W'(5))) + NODE_AW'(4);
		end
		return r;
	endfunction

	function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

### hdl/bta_engine.sv
// Tree walker: node bit memory, layer memory and the sequencer over them.
module bta_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bta_pkg::req_t      req,
	input  logic               res_ready,
	output bta_pkg::eng_stat_t stat,
	output bta_pkg::res_t      res
);

	localparam logic [bta_pkg::LAYER_W-1:0] LAST_LAYER = bta_pkg::LAYER_W'(bta_pkg::TREE_DEPTH);

	logic [bta_pkg::WORD_W-1:0]  node_mem [bta_pkg::NODE_WORDS];
	logic [bta_pkg::LAYER_W-1:0] ls_mem   [2**bta_pkg::UNIT_W];
	logic [bta_pkg::WORD_W-1:0]  node_rd_q;
	logic [bta_pkg::LAYER_W-1:0] ls_rd_q;

	logic                         node_re, node_we, ls_re, ls_we;
	logic [bta_pkg::NODE_AW-1:0]  node_raddr, node_waddr;
	logic [bta_pkg::WORD_W-1:0]   node_wdata;
	logic [bta_pkg::UNIT_W-1:0]   ls_raddr, ls_waddr;

	bta_pkg::state_t state_q, state_d;

	bta_pkg::op_t                 op_q;
	logic [bta_pkg::LAYER_W-1:0]  layer_q, d_q, a_q;
	logic [bta_pkg::CLIENT_W-1:0] client_q;
	logic [bta_pkg::UNIT_W-1:0]   unit_q, pos_q, apos_q;
	logic [bta_pkg::WIDX_W-1:0]   fill_q, ra_w_q, dw_s1;
	logic                         pass_q, issue_q, dv_s1;
	logic [bta_pkg::WORD_W-1:0]   child_q;
	logic [bta_pkg::NODE_AW-1:0]  init_q;
	logic [bta_pkg::ADDR_W-1:0]   res_addr_q;
	logic                         res_fail_q;

	// subtree pass
	logic [bta_pkg::LAYER_W-1:0]  sub_n;
	logic [bta_pkg::UNIT_W-1:0]   sub_st;
	logic [bta_pkg::NODE_AW-1:0]  sub_addr;
	logic                         sub_rmw, sub_val, sub_done;
	logic [bta_pkg::WORD_W-1:0]   sub_mask, sub_new;
	logic [bta_pkg::WIDX_W-1:0]   fill_last;

	// layer search
	logic [bta_pkg::UNIT_W:0]     lay_nodes, scan_cnt;
	logic [bta_pkg::UNIT_W-1:0]   scan_lo;
	logic [bta_pkg::WIDX_W-1:0]   scan_first, scan_last;
	logic [bta_pkg::WORD_W-1:0]   scan_mask, scan_hits;
	logic                         scan_hit, scan_end;
	logic [bta_pkg::UNIT_W-1:0]   hit_pos;

	// ancestor pass
	logic [bta_pkg::LAYER_W-1:0]  par_layer;
	logic [bta_pkg::UNIT_W-1:0]   par_pos;
	logic [bta_pkg::NODE_AW-1:0]  anc_addr;
	logic                         both;
	logic [bta_pkg::WORD_W-1:0]   anc_new;

	logic [bta_pkg::UNIT_W-1:0]   free_pos, blk_start;

	always_comb begin
		sub_n     = d_q - layer_q;
		sub_st    = pos_q << sub_n;
		sub_addr  = bta_pkg::layer_base(d_q) + bta_pkg::NODE_AW'(sub_st >> 5);
		sub_rmw   = sub_n < bta_pkg::LAYER_W'(5);
		sub_val   = op_q == bta_pkg::OP_FREE;
		sub_mask  = ((bta_pkg::WORD_W'(1) << (bta_pkg::WORD_W'(1) << sub_n))
			- bta_pkg::WORD_W'(1)) << sub_st[bta_pkg::BIT_W-1:0];
		sub_new   = sub_val ? (node_rd_q | sub_mask) : (node_rd_q & ~sub_mask);
		fill_last = bta_pkg::WIDX_W'((12'(1) << (sub_n - bta_pkg::LAYER_W'(5))) - 12'(1));
		sub_done  = d_q == LAST_LAYER;
	end

	always_comb begin
		lay_nodes  = (bta_pkg::UNIT_W+1)'(1) << layer_q;
		scan_lo    = pass_q ? '0
			: (bta_pkg::UNIT_W'(client_q) << (layer_q - bta_pkg::LAYER_W'(2)));
		scan_cnt   = pass_q ? lay_nodes : (lay_nodes >> 2);
		scan_first = bta_pkg::WIDX_W'(scan_lo >> 5);
		scan_last  = bta_pkg::WIDX_W'(((bta_pkg::UNIT_W+1)'(scan_lo) + scan_cnt
			- (bta_pkg::UNIT_W+1)'(1)) >> 5);
		if (scan_cnt < (bta_pkg::UNIT_W+1)'(bta_pkg::WORD_W)) begin
			scan_mask = ((bta_pkg::WORD_W'(1) << scan_cnt[bta_pkg::BIT_W-1:0])
				- bta_pkg::WORD_W'(1)) << scan_lo[bta_pkg::BIT_W-1:0];
		end else begin
			scan_mask = '1;
		end
		scan_hits = node_rd_q & scan_mask;
		scan_hit  = dv_s1 && (|scan_hits);
		scan_end  = dv_s1 && !(|scan_hits) && (dw_s1 == scan_last);
		hit_pos   = {dw_s1, bta_pkg::first_set(scan_hits)};
	end

	always_comb begin
		par_layer = a_q - bta_pkg::LAYER_W'(1);
		par_pos   = apos_q >> 1;
		anc_addr  = bta_pkg::layer_base(par_layer) + bta_pkg::NODE_AW'(par_pos >> 5);
		both      = child_q[{apos_q[bta_pkg::BIT_W-1:1], 1'b0}]
			& child_q[{apos_q[bta_pkg::BIT_W-1:1], 1'b1}];
		anc_new   = (node_rd_q & ~(bta_pkg::WORD_W'(1) << par_pos[bta_pkg::BIT_W-1:0]))
			| (bta_pkg::WORD_W'(both) << par_pos[bta_pkg::BIT_W-1:0]);
		free_pos  = unit_q >> (LAST_LAYER - ls_rd_q);
		blk_start = pos_q << (LAST_LAYER - layer_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bta_pkg::ST_INIT: begin
				if (init_q == bta_pkg::NODE_AW'(bta_pkg::NODE_WORDS - 1)) begin
					state_d = bta_pkg::ST_IDLE;
				end
			end
			bta_pkg::ST_IDLE: begin
				if (start) begin
					if (req.op == bta_pkg::OP_FREE) begin
						state_d = bta_pkg::ST_LRD;
					end else if (req.oversize) begin
						state_d = bta_pkg::ST_RESULT;
					end else begin
						state_d = bta_pkg::ST_SCAN_INIT;
					end
				end
			end
			bta_pkg::ST_LRD: begin
				state_d = (ls_rd_q > LAST_LAYER) ? bta_pkg::ST_IDLE : bta_pkg::ST_SUB_RD;
			end
			bta_pkg::ST_SCAN_INIT: state_d = bta_pkg::ST_SCAN;
			bta_pkg::ST_SCAN: begin
				if (scan_hit) begin
					state_d = bta_pkg::ST_SUB_RD;
				end else if (scan_end) begin
					state_d = pass_q ? bta_pkg::ST_RESULT : bta_pkg::ST_SCAN_INIT;
				end
			end
			bta_pkg::ST_SUB_RD: begin
				if (sub_rmw) begin
					state_d = bta_pkg::ST_SUB_WR;
				end else if (fill_q == fill_last && sub_done) begin
					state_d = (layer_q == '0) ? bta_pkg::ST_FINISH : bta_pkg::ST_ANC_RD;
				end
			end
			bta_pkg::ST_SUB_WR: begin
				if (sub_done) begin
					state_d = (layer_q == '0) ? bta_pkg::ST_FINISH : bta_pkg::ST_ANC_RD;
				end else begin
					state_d = bta_pkg::ST_SUB_RD;
				end
			end
			bta_pkg::ST_ANC_RD: state_d = bta_pkg::ST_ANC_WR;
			bta_pkg::ST_ANC_WR: begin
				state_d = (a_q == bta_pkg::LAYER_W'(1)) ? bta_pkg::ST_FINISH : bta_pkg::ST_ANC_RD;
			end
			bta_pkg::ST_FINISH: begin
				state_d = (op_q == bta_pkg::OP_ALLOC) ? bta_pkg::ST_RESULT : bta_pkg::ST_IDLE;
			end
			bta_pkg::ST_RESULT: begin
				if (res_ready) begin
					state_d = bta_pkg::ST_IDLE;
				end
			end
			default: state_d = bta_pkg::ST_INIT;
		endcase
	end

	// memory ports and status
	always_comb begin
		node_re    = 1'b0;
		node_raddr = '0;
		node_we    = 1'b0;
		node_waddr = '0;
		node_wdata = '0;
		ls_re      = 1'b0;
		ls_raddr   = req.unit;
		ls_we      = 1'b0;
		ls_waddr   = blk_start;
		unique case (state_q)
			bta_pkg::ST_INIT: begin
				node_we    = 1'b1;
				node_waddr = init_q;
				node_wdata = '1;
			end
			bta_pkg::ST_IDLE: ls_re = start && (req.op == bta_pkg::OP_FREE);
			bta_pkg::ST_SCAN: begin
				node_re    = issue_q;
				node_raddr = bta_pkg::layer_base(layer_q) + bta_pkg::NODE_AW'(ra_w_q);
			end
			bta_pkg::ST_SUB_RD: begin
				if (sub_rmw) begin
					node_re    = 1'b1;
					node_raddr = sub_addr;
				end else begin
					node_we    = 1'b1;
					node_waddr = sub_addr + bta_pkg::NODE_AW'(fill_q);
					node_wdata = sub_val ? '1 : '0;
				end
			end
			bta_pkg::ST_SUB_WR: begin
				node_we    = 1'b1;
				node_waddr = sub_addr;
				node_wdata = sub_new;
			end
			bta_pkg::ST_ANC_RD: begin
				node_re    = 1'b1;
				node_raddr = anc_addr;
			end
			bta_pkg::ST_ANC_WR: begin
				node_we    = 1'b1;
				node_waddr = anc_addr;
				node_wdata = anc_new;
			end
			bta_pkg::ST_FINISH: ls_we = op_q == bta_pkg::OP_ALLOC;
			default: ;
		endcase
		stat.ready     = state_q == bta_pkg::ST_IDLE;
		stat.res_valid = state_q == bta_pkg::ST_RESULT;
		res.addr       = res_addr_q;
		res.failed     = res_fail_q;
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= node_wdata;
		end
		if (node_re) begin
			node_rd_q <= node_mem[node_raddr];
		end
		if (ls_we) begin
			ls_mem[ls_waddr] <= layer_q;
		end
		if (ls_re) begin
			ls_rd_q <= ls_mem[ls_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bta_pkg::ST_INIT;
			init_q  <= '0;
			issue_q <= 1'b0;
			dv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			dv_s1   <= (state_q == bta_pkg::ST_SCAN) && issue_q;
			if (state_q == bta_pkg::ST_INIT) begin
				init_q <= init_q + bta_pkg::NODE_AW'(1);
			end
			if (state_q == bta_pkg::ST_SCAN_INIT) begin
				issue_q <= 1'b1;
			end else if (state_q == bta_pkg::ST_SCAN && issue_q) begin
				issue_q <= ra_w_q != scan_last;
			end else begin
				issue_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		dw_s1 <= ra_w_q;
		case (state_q)
			bta_pkg::ST_IDLE: begin
				if (start) begin
					op_q       <= req.op;
					layer_q    <= req.layer;
					client_q   <= req.client;
					unit_q     <= req.unit;
					pass_q     <= req.layer < bta_pkg::LAYER_W'(2);
					fill_q     <= '0;
					res_addr_q <= '0;
					res_fail_q <= 1'b1;
				end
			end
			bta_pkg::ST_LRD: begin
				layer_q <= ls_rd_q;
				d_q     <= ls_rd_q;
				pos_q   <= free_pos;
			end
			bta_pkg::ST_SCAN_INIT: ra_w_q <= scan_first;
			bta_pkg::ST_SCAN: begin
				if (issue_q) begin
					ra_w_q <= ra_w_q + bta_pkg::WIDX_W'(1);
				end
				if (scan_hit) begin
					pos_q <= hit_pos;
					d_q   <= layer_q;
				end else if (scan_end) begin
					pass_q <= 1'b1;
				end
			end
			bta_pkg::ST_SUB_RD: begin
				if (!sub_rmw) begin
					if (fill_q == fill_last) begin
						fill_q <= '0;
						if (sub_done) begin
							a_q    <= layer_q;
							apos_q <= pos_q;
						end else begin
							d_q <= d_q + bta_pkg::LAYER_W'(1);
						end
					end else begin
						fill_q <= fill_q + bta_pkg::WIDX_W'(1);
					end
				end
			end
			bta_pkg::ST_SUB_WR: begin
				if (d_q == layer_q) begin
					child_q <= sub_new;
				end
				if (sub_done) begin
					a_q    <= layer_q;
					apos_q <= pos_q;
				end else begin
					d_q <= d_q + bta_pkg::LAYER_W'(1);
				end
			end
			bta_pkg::ST_ANC_WR: begin
				child_q <= anc_new;
				a_q     <= par_layer;
				apos_q  <= par_pos;
			end
			bta_pkg::ST_FINISH: begin
				if (op_q == bta_pkg::OP_ALLOC) begin
					res_addr_q <= {blk_start, bta_pkg::UNIT_SHIFT'(0)};
					res_fail_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

endmodule

### hdl/buddy_tree_allocator.sv
// Top level of the buddy tree allocator: request sizing, handshakes, result register.
//
//  channel  | dir | tdata                                       | tuser
//  s_axis   | in  | request_bytes, client, free_address (56 b)  | opcode
//  m_axis   | out | block_address (32 b)                        | failed
//
// One item at a time. Allocate: one word scanned per cycle (32 nodes a word, a second pass
// when the client quarter is full), then a read and a write per partial subtree word, one write
// per whole word, and a read and a write per ancestor. Free: a layer memory read, then the same
// subtree and ancestor walk, all on one node memory port pair.
// After reset the node memory, all 4100 words, is set to all free before the first item.
// A held m_axis result does not block input; the engine waits only on a second result.
module buddy_tree_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// request_bytes[25:0], client[27:26], free_address[52:28]
	input  logic [bta_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// opcode
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// block_address[24:0]
	output logic [bta_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// failed
	output logic                              m_axis_tuser
);

	logic [bta_pkg::BYTES_W-1:0]  req_bytes;
	logic [bta_pkg::ADDR_W-1:0]   req_faddr;
	logic [bta_pkg::BYTES_W:0]    bytes_up;
	logic [bta_pkg::UNITS_W-1:0]  units, units_m1;
	logic [bta_pkg::LAYER_W-1:0]  size_log;

	bta_pkg::req_t      req;
	bta_pkg::res_t      eng_res;
	bta_pkg::eng_stat_t eng_stat;
	logic               start, res_ready;

	logic                         m_valid_q;
	logic [bta_pkg::ADDR_W-1:0]   m_addr_q;
	logic                         m_fail_q;

	always_comb begin
		req_bytes = s_axis_tdata[bta_pkg::BYTES_W-1:0];
		req_faddr = s_axis_tdata[52:28];
		bytes_up  = {1'b0, req_bytes} + (bta_pkg::BYTES_W+1)'((1 << bta_pkg::UNIT_SHIFT) - 1);
		units     = bta_pkg::UNITS_W'(bytes_up >> bta_pkg::UNIT_SHIFT);
		if (units == '0) begin
			units = bta_pkg::UNITS_W'(1);
		end
		units_m1 = units - bta_pkg::UNITS_W'(1);
		size_log = '0;
		for (int i = 0; i < bta_pkg::TREE_DEPTH; i++) begin
			if (units_m1[i]) begin
				size_log = bta_pkg::LAYER_W'(i + 1);
			end
		end
		req.op       = bta_pkg::op_t'(s_axis_tuser);
		req.oversize = units > bta_pkg::UNITS_W'(1 << bta_pkg::TREE_DEPTH);
		req.layer    = bta_pkg::LAYER_W'(bta_pkg::TREE_DEPTH) - size_log;
		req.client   = s_axis_tdata[27:26];
		req.unit     = bta_pkg::UNIT_W'(req_faddr >> bta_pkg::UNIT_SHIFT);
	end

	assign s_axis_tready = eng_stat.ready;
	assign start         = s_axis_tvalid && eng_stat.ready;
	assign res_ready     = !m_valid_q || m_axis_tready;

	bta_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.res_ready (res_ready),
		.stat      (eng_stat),
		.res       (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= eng_stat.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && eng_stat.res_valid) begin
			m_addr_q <= eng_res.addr;
			m_fail_q <= eng_res.failed;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = bta_pkg::OUT_DATA_W'(m_addr_q);
	assign m_axis_tuser  = m_fail_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("failed result carries an address");

	a_unit_align: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[bta_pkg::UNIT_SHIFT-1:0] == '0)
		else $error("block address not unit aligned");

	a_free_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && s_axis_tuser |=> !eng_stat.res_valid && !eng_stat.ready)
		else $error("free item produced a result or was dropped");

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		eng_stat.ready |-> !eng_stat.res_valid)
		else $error("engine idle with a pending result");

endmodule

### tb/tb_buddy_tree_allocator.sv
// Testbench for the buddy tree allocator: random and directed allocate/free traffic.

class alloc_tracker;
	typedef struct {
		logic [bta_pkg::ADDR_W-1:0] addr;
		logic                       failed;
	} outcome_t;

	bit                         node_free[(2 << bta_pkg::TREE_DEPTH) - 1];
	bit [bta_pkg::LAYER_W-1:0]  layer_of[1 << bta_pkg::TREE_DEPTH];
	bit                         stored[1 << bta_pkg::TREE_DEPTH];
	outcome_t                   pending_q[$];
	bit [bta_pkg::ADDR_W-1:0]   live_q[$];
	bit [bta_pkg::ADDR_W-1:0]   used_q[$];
	int                         mismatches;

	function new();
		foreach (node_free[i]) node_free[i] = 1'b1;
		mismatches = 0;
	endfunction

	function int idx(int layer, int pos);
		return (1 << layer) - 1 + pos;
	endfunction

	function void fill(int layer, int pos, bit v);
		for (int d = layer; d <= bta_pkg::TREE_DEPTH; d++) begin
			for (int j = 0; j < (1 << (d - layer)); j++) begin
				node_free[idx(d, (pos << (d - layer)) + j)] = v;
			end
		end
	endfunction

	function bit find(int layer, int lo, int cnt, output int pos);
		pos = 0;
		for (int i = lo; i < lo + cnt; i++) begin
			if (node_free[idx(layer, i)]) begin
				pos = i;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function void note_request(bta_pkg::op_t op, bit [bta_pkg::BYTES_W-1:0] bytes,
			bit [bta_pkg::CLIENT_W-1:0] client, bit [bta_pkg::ADDR_W-1:0] faddr);
		longint   units;
		int       k, layer, nodes, q, pos, start, unit, l;
		bit       ok, both;
		outcome_t o;
		if (op == bta_pkg::OP_ALLOC) begin
			units = (longint'(bytes) + (1 << bta_pkg::UNIT_SHIFT) - 1) >> bta_pkg::UNIT_SHIFT;
			if (units == 0) units = 1;
			o.addr = '0;
			o.failed = 1'b1;
			if (units <= (longint'(1) << bta_pkg::TREE_DEPTH)) begin
				k = 0;
				while ((longint'(1) << k) < units) k++;
				layer = bta_pkg::TREE_DEPTH - k;
				nodes = 1 << layer;
				ok = 1'b0;
				if (nodes >= 4) begin
					q = nodes >> 2;
					ok = find(layer, int'(client) * q, q, pos);
				end
				if (!ok) ok = find(layer, 0, nodes, pos);
				if (ok) begin
					fill(layer, pos, 1'b0);
					l = layer;
					start = pos;
					while (l > 0) begin
						l--;
						start >>= 1;
						node_free[idx(l, start)] = 1'b0;
					end
					start = pos << (bta_pkg::TREE_DEPTH - layer);
					layer_of[start] = bta_pkg::LAYER_W'(layer);
					o.addr = bta_pkg::ADDR_W'(start) << bta_pkg::UNIT_SHIFT;
					o.failed = 1'b0;
					live_q.push_back(o.addr);
					if (!stored[start]) used_q.push_back(o.addr);
					stored[start] = 1'b1;
				end
			end
			pending_q.push_back(o);
		end else begin
			unit = int'(faddr >> bta_pkg::UNIT_SHIFT);
			layer = layer_of[unit];
			pos = unit >> (bta_pkg::TREE_DEPTH - layer);
			fill(layer, pos, 1'b1);
			while (layer > 0) begin
				l = idx(layer, pos & ~1);
				both = node_free[l] & node_free[l + 1];
				layer--;
				pos >>= 1;
				node_free[idx(layer, pos)] = both;
			end
		end
	endfunction

	function void check_result(logic [bta_pkg::OUT_DATA_W-1:0] data, logic fl);
		outcome_t o;
		if (pending_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result addr=%h failed=%b", data, fl);
			return;
		end
		o = pending_q.pop_front();
		if (data !== bta_pkg::OUT_DATA_W'(o.addr) || fl !== o.failed) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected addr=%h failed=%b, got addr=%h failed=%b",
					o.addr, o.failed, data, fl);
		end
	endfunction
endclass

module tb_buddy_tree_allocator;
	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [bta_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic                           s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [bta_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tuser;

	alloc_tracker tracker = new();
	bit  tx_quiet;
	int  rx_count = 0;
	int  idle_cycles = 0;

	buddy_tree_allocator u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 1'b0;
		m_axis_tready <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 200000) begin
			$display("FAIL buddy_tree_allocator");
			$finish;
		end
	end

	task automatic send_item(bta_pkg::op_t op, bit [bta_pkg::BYTES_W-1:0] bytes,
			bit [bta_pkg::CLIENT_W-1:0] client, bit [bta_pkg::ADDR_W-1:0] faddr);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {3'b0, faddr, client, bytes};
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_request(op, bytes, client, faddr);
	endtask

	task automatic do_alloc(bit [bta_pkg::BYTES_W-1:0] bytes, bit [bta_pkg::CLIENT_W-1:0] client);
		send_item(bta_pkg::OP_ALLOC, bytes, client, bta_pkg::ADDR_W'($urandom));
	endtask

	// live block most of the time, else a stale or unaligned address of a written unit
	task automatic do_free();
		bit [bta_pkg::ADDR_W-1:0] a;
		int i;
		if (tracker.live_q.size() > 0 && $urandom_range(0, 9) < 8) begin
			i = $urandom_range(0, tracker.live_q.size() - 1);
			a = tracker.live_q[i];
			tracker.live_q.delete(i);
		end else if (tracker.used_q.size() > 0) begin
			a = tracker.used_q[$urandom_range(0, tracker.used_q.size() - 1)];
			a[bta_pkg::UNIT_SHIFT-1:0] = bta_pkg::UNIT_SHIFT'($urandom);
		end else begin
			do_alloc(bta_pkg::BYTES_W'($urandom_range(0, 2048)), bta_pkg::CLIENT_W'($urandom));
			return;
		end
		send_item(bta_pkg::OP_FREE, bta_pkg::BYTES_W'($urandom), bta_pkg::CLIENT_W'($urandom), a);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_q.size() > 0) @(posedge clk);
	endtask

	initial begin
		int stall;
		int held_at;
		held_at = -1;
		@(posedge arst_n);
		forever begin
			stall = ((rx_count / 100) % 5 == 2) ? 0 : $urandom_range(0, 6);
			if ((rx_count == 300 || rx_count == 1000) && held_at != rx_count) begin
				held_at = rx_count;
				stall = 3000;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			tracker.check_result(m_axis_tdata, m_axis_tuser);
			rx_count++;
		end
	end

	initial begin
		int r;
		bit [bta_pkg::BYTES_W-1:0] bytes;
		tx_quiet = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		do_alloc(0, 0);
		do_alloc(1, 1);
		do_alloc(512, 2);
		do_alloc(513, 3);
		do_alloc(26'h3FF_FFFF, 0);
		do_alloc(26'd33554433, 1);
		while (tracker.live_q.size() > 0) do_free();
		do_alloc(26'd33554432, 2);
		do_alloc(1, 3);
		do_free();
		do_alloc(26'd16777216, 3);
		do_alloc(26'd8388608, 3);
		do_alloc(26'd8388608, 3);
		do_alloc(26'd4194304, 1);
		do_alloc(700, 2);
		send_item(bta_pkg::OP_FREE, 0, 0,
			bta_pkg::ADDR_W'(tracker.used_q[0]) | bta_pkg::ADDR_W'(9'h1FF));
		send_item(bta_pkg::OP_FREE, 0, 0, tracker.used_q[0]);
		while (tracker.live_q.size() > 0) do_free();
		for (int n = 0; n < 1900; n++) begin
			tx_quiet = ((n / 100) % 5 == 4);
			if (n == 900) drain();
			if ($urandom_range(0, 99) < (tracker.live_q.size() > 150 ? 70 : 40)) begin
				do_free();
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) bytes = $urandom_range(0, 4096);
				else if (r < 90) bytes = $urandom_range(0, 1 << 18);
				else if (r < 97) bytes = $urandom_range(0, 1 << 25);
				else bytes = bta_pkg::BYTES_W'($urandom);
				do_alloc(bytes, bta_pkg::CLIENT_W'($urandom));
			end
		end
		s_axis_tvalid <= 1'b0;
		drain();
		repeat (10000) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_q.size() == 0)
			$display("PASS buddy_tree_allocator");
		else
			$display("FAIL buddy_tree_allocator");
		$finish;
	end
endmodule
